FILE: hw/rtl/ppru_pkg.sv
`default_nettype none

package ppru_pkg;

    localparam int BYTE_W     = 8;
    localparam int CHANNEL_W  = 5;
    localparam int SLOT_W     = 3;
    localparam int FLAGS_W    = 3;
    localparam int ROW_W      = 8;
    localparam int CH_COUNT_W = 6;
    localparam int ROWS_W     = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PATTERN = 1'd1;

    localparam logic [CH_COUNT_W-1:0] CHANNEL_COUNT_RESET    = 6'd32;
    localparam logic [ROWS_W-1:0]     ROWS_PER_PATTERN_RESET = 9'd64;
    localparam logic [ROWS_W-1:0]     ROWS_MAX               = 9'd256;

    // pending flag bits (control byte bits 7:5)
    localparam int FLAG_NOTE_BIT = 0;
    localparam int FLAG_VOL_BIT  = 1;
    localparam int FLAG_FX_BIT   = 2;

    // cell slots
    localparam logic [SLOT_W-1:0] SLOT_NOTE  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_INSTR = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_VOL   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_FX    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_PARAM = 3'd4;

    // result kinds
    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_ROW_END = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ROW_W-1:0]     row_index;
        logic [CHANNEL_W-1:0] channel;
        logic [SLOT_W-1:0]    slot;
        logic [BYTE_W-1:0]    value;
        logic                 out_of_range;
        logic                 pattern_done;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ppru_if.sv
`default_nettype none

interface ppru_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ppru_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ppru_result_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [ppru_pkg::ROW_W-1:0]      row_index;
    logic [ppru_pkg::CHANNEL_W-1:0]  channel;
    logic [ppru_pkg::SLOT_W-1:0]     slot;
    logic [ppru_pkg::BYTE_W-1:0]     value;
    logic                            out_of_range;
    logic                            pattern_done;

    modport source (output valid, output kind, output row_index, output channel,
                    output slot, output value, output out_of_range,
                    output pattern_done, input ready);
    modport sink (input valid, input kind, input row_index, input channel,
                  input slot, input value, input out_of_range,
                  input pattern_done, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/packed_pattern_row_unpacker_unit.sv
`default_nettype none

// Packed pattern row unpacker. Takes one byte of the packed stream per cycle
// on "pattern" and returns at most one result per byte on "result", in the cycle
// after the byte is accepted. Decode state lives in a few small registers
// that update on every accepted byte, and each result lands in a single output
// register, so a byte is taken in every cycle in which that register is empty
// or being drained; only a stalled result holds off the input. Control bytes
// with flags yield no result. channel_count and rows_per_pattern are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the stream is idle, as the block does not enforce it.
module packed_pattern_row_unpacker_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ppru_byte_if.sink                              pattern,
    ppru_result_if.source                          result,
    input  wire logic                              cfg_we,
    input  wire logic [ppru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppru_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppru_pkg::*;

    logic [CH_COUNT_W-1:0] channel_count_reg;
    logic [ROWS_W-1:0]     rows_per_pattern_reg;

    logic [CHANNEL_W-1:0]  channel_reg, channel_next;
    logic [FLAGS_W-1:0]    flags_reg, flags_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    result_t               res_reg, res_next;
    logic                  res_valid_reg;
    logic                  res_fire;
    logic                  accept;

    logic [ROWS_W-1:0]     rows_eff;
    logic [ROWS_W-1:0]     row_plus1;
    logic                  done;
    logic [FLAGS_W-1:0]    flags_tmp;
    logic [SLOT_W-1:0]     slot_tmp;

    function automatic logic [SLOT_W-1:0] first_slot(input logic [FLAGS_W-1:0] f);
        if (f[FLAG_NOTE_BIT])
            return SLOT_NOTE;
        else if (f[FLAG_VOL_BIT])
            return SLOT_VOL;
        else
            return SLOT_FX;
    endfunction

    assign pattern.ready = !res_valid_reg || result.ready;
    assign accept        = pattern.valid && pattern.ready;

    always_comb
    begin
        if (rows_per_pattern_reg == '0)
            rows_eff = ROWS_W'(1);
        else if (rows_per_pattern_reg > ROWS_MAX)
            rows_eff = ROWS_MAX;
        else
            rows_eff = rows_per_pattern_reg;
        row_plus1 = {1'b0, row_reg} + ROWS_W'(1);
        done      = row_plus1 >= rows_eff;
    end

    always_comb
    begin
        channel_next = channel_reg;
        flags_next   = flags_reg;
        slot_next    = slot_reg;
        row_next     = row_reg;
        res_next     = '0;
        res_fire     = 1'b0;
        flags_tmp    = flags_reg;
        slot_tmp     = slot_reg;

        if (accept)
        begin
            if (flags_reg == '0)
            begin
                if (pattern.data_byte == '0)
                begin
                    res_fire              = 1'b1;
                    res_next.kind         = KIND_ROW_END;
                    res_next.row_index    = row_reg;
                    res_next.pattern_done = done;
                    row_next              = done ? '0 : row_plus1[ROW_W-1:0];
                end
                else
                begin
                    channel_next = pattern.data_byte[CHANNEL_W-1:0];
                    flags_next   = pattern.data_byte[BYTE_W-1:BYTE_W-FLAGS_W];
                    if (flags_next != '0)
                        slot_next = first_slot(flags_next);
                end
            end
            else
            begin
                res_fire              = 1'b1;
                res_next.kind         = KIND_CELL;
                res_next.row_index    = row_reg;
                res_next.channel      = channel_reg;
                res_next.slot         = slot_reg;
                res_next.value        = pattern.data_byte;
                res_next.out_of_range = {1'b0, channel_reg} >= channel_count_reg;

                case (slot_reg)
                    SLOT_NOTE:  slot_tmp = SLOT_INSTR;
                    SLOT_INSTR: flags_tmp[FLAG_NOTE_BIT] = 1'b0;
                    SLOT_VOL:   flags_tmp[FLAG_VOL_BIT] = 1'b0;
                    SLOT_FX:    slot_tmp = SLOT_PARAM;
                    default:    flags_tmp[FLAG_FX_BIT] = 1'b0;
                endcase
                // unless the fx parameter is next, go to the first slot whose flag is still set
                if (slot_tmp != SLOT_NOTE && slot_tmp != SLOT_PARAM && flags_tmp != '0)
                    slot_tmp = first_slot(flags_tmp);
                if (flags_tmp == '0)
                    slot_tmp = SLOT_NOTE;
                flags_next = flags_tmp;
                slot_next  = slot_tmp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg    <= CHANNEL_COUNT_RESET;
            rows_per_pattern_reg <= ROWS_PER_PATTERN_RESET;
            channel_reg          <= '0;
            flags_reg            <= '0;
            slot_reg             <= SLOT_NOTE;
            row_reg              <= '0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT:    channel_count_reg <= cfg_data[CH_COUNT_W-1:0];
                    CFG_ROWS_PER_PATTERN: rows_per_pattern_reg <= cfg_data[ROWS_W-1:0];
                    default:              ;
                endcase
            end
            channel_reg <= channel_next;
            flags_reg   <= flags_next;
            slot_reg    <= slot_next;
            row_reg     <= row_next;
            if (accept && res_fire)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
            res_reg <= res_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.kind         = res_reg.kind;
    assign result.row_index    = res_reg.row_index;
    assign result.channel      = res_reg.channel;
    assign result.slot         = res_reg.slot;
    assign result.value        = res_reg.value;
    assign result.out_of_range = res_reg.out_of_range;
    assign result.pattern_done = res_reg.pattern_done;

endmodule

`default_nettype wire

FILE: hw/rtl/ppru_checker.sv
`default_nettype none

module ppru_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_ready,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic                            kind,
    input  wire logic [ppru_pkg::CHANNEL_W-1:0]  channel,
    input  wire logic [ppru_pkg::SLOT_W-1:0]     slot,
    input  wire logic [ppru_pkg::BYTE_W-1:0]     value,
    input  wire logic                            out_of_range,
    input  wire logic                            pattern_done
);
    import ppru_pkg::*;

    // a stalled result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a pending result that is not taken blocks the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // an empty output register always takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    a_row_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ROW_END |->
            channel == '0 && slot == '0 && value == '0 && !out_of_range)
        else $error("row end carries cell fields");

    a_cell_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CELL |-> !pattern_done && slot <= SLOT_PARAM)
        else $error("bad cell write fields");

endmodule

bind packed_pattern_row_unpacker_unit ppru_checker u_ppru_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pattern.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .kind         (result.kind),
    .channel      (result.channel),
    .slot         (result.slot),
    .value        (result.value),
    .out_of_range (result.out_of_range),
    .pattern_done (result.pattern_done)
);

`default_nettype wire
